>>> sv/supe_pkg.sv
// ----------------------------------------------------------------------------
// supe_pkg: shared definitions for the unit propagation engine
// Command codes, result kinds and variable state codes.
// ----------------------------------------------------------------------------
package supe_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_ADD_LIT   = 3'd1,
        OP_PRESET    = 3'd2,
        OP_PROPAGATE = 3'd3,
        OP_QUERY     = 3'd4
    } t_op;

    localparam logic RK_PROP  = 1'b0;
    localparam logic RK_QUERY = 1'b1;

    localparam logic [1:0] VS_OPEN  = 2'd0;
    localparam logic [1:0] VS_TRUE  = 2'd1;
    localparam logic [1:0] VS_FALSE = 2'd2;

    localparam int unsigned IDX_W    = 7;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned LEFT_W   = 11;

endpackage

>>> sv/sat_unit_propagation_engine_core.sv
// ----------------------------------------------------------------------------
// sat_unit_propagation_engine_core: boolean constraint propagation engine
// Clause store loaded one literal at a time; propagate sweeps it until stable.
// ----------------------------------------------------------------------------
// Usage: one command channel (start/busy) and one result channel (o_valid).
// A command transfers at a clock edge with start high and busy low.
// Clear, add literal and preset give no result.
// Query gives its answer in the cycle after the transfer, with o_valid high.
// Propagate raises busy and walks the clause memory through one shared
// clause evaluator: each clause is a memory read, then an evaluate and
// write back of the reduced clause at its compacted slot.
// Passes repeat until no variable is assigned, or stop at the first
// contradiction. The report appears with o_valid for one cycle as busy
// falls.
// Results are shown for exactly one cycle; the receiver cannot stall.
// Reset clears the assignment, the clause count and the open clause.
// The clause memory is not cleared: slots are written before they are read.
// ----------------------------------------------------------------------------
module sat_unit_propagation_engine_core
    import supe_pkg::*;
#(
    parameter int unsigned NUM_VARS         = 128,
    parameter int unsigned MAX_CLAUSE_SLOTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [2:0]         i_op,
    input  logic [IDX_W-1:0]   i_var_index,
    input  logic               i_polarity,
    input  logic               i_clause_end,
    output logic               busy,
    output logic               o_valid,
    output logic               o_result_kind,
    output logic               o_contradiction,
    output logic [COUNT_W-1:0] o_assigned_count,
    output logic [LEFT_W-1:0]  o_clauses_left,
    output logic [1:0]         o_var_state
);

    localparam int unsigned CW = $clog2(MAX_CLAUSE_SLOTS + 1);
    localparam int unsigned AW = $clog2(MAX_CLAUSE_SLOTS);
    localparam int unsigned RW = 2 * NUM_VARS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL
    } t_state;

    t_state              r_state;
    logic [NUM_VARS-1:0] r_true;
    logic [NUM_VARS-1:0] r_false;
    logic [NUM_VARS-1:0] r_cur_pos;
    logic [NUM_VARS-1:0] r_cur_neg;
    logic                r_open;
    logic [CW-1:0]       r_count;
    logic [COUNT_W-1:0]  r_assigned;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_kept;
    logic                r_changed;
    logic [RW-1:0]       r_rd;

    logic [RW-1:0]       mem_row [MAX_CLAUSE_SLOTS];

    logic                accept;
    logic [NUM_VARS-1:0] lit_bit;
    logic [NUM_VARS-1:0] new_pos;
    logic [NUM_VARS-1:0] new_neg;
    logic                store_full;
    logic [NUM_VARS-1:0] p_row;
    logic [NUM_VARS-1:0] n_row;
    logic [NUM_VARS-1:0] assigned_mask;
    logic [NUM_VARS-1:0] pl;
    logic [NUM_VARS-1:0] nl;
    logic [NUM_VARS-1:0] open_bits;
    logic                clause_sat;
    logic                clause_empty;
    logic                clause_unit;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [RW-1:0]       mem_wdata;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // decode the literal bit; zero when the variable is out of range
    assign lit_bit    = {{(NUM_VARS-1){1'b0}}, 1'b1} << i_var_index;
    assign store_full = !r_open && (r_count >= CW'(MAX_CLAUSE_SLOTS));
    assign new_pos    = (r_open ? r_cur_pos : '0) | (i_polarity ? lit_bit : '0);
    assign new_neg    = (r_open ? r_cur_neg : '0) | (i_polarity ? '0 : lit_bit);

    // shared clause evaluator
    assign p_row         = r_rd[NUM_VARS-1:0];
    assign n_row         = r_rd[RW-1:NUM_VARS];
    assign assigned_mask = r_true | r_false;
    assign clause_sat    = |((p_row & r_true) | (n_row & r_false));
    assign pl            = p_row & ~assigned_mask;
    assign nl            = n_row & ~assigned_mask;
    assign open_bits     = pl | nl;
    assign clause_empty  = (open_bits == '0);
    assign clause_unit   = !clause_empty && ((open_bits & (open_bits - 1'b1)) == '0);

    // select the memory write source: clause load or compaction
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wdata = {new_neg, new_pos};
        if (r_state == S_EVAL) begin
            mem_we    = !clause_sat && !clause_empty;
            mem_waddr = r_kept[AW-1:0];
            mem_wdata = {nl, pl};
        end else if (accept && (i_op == OP_ADD_LIT) && !store_full && i_clause_end) begin
            mem_we = 1'b1;
        end
    end

    // clause memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_row[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem_row[r_idx[AW-1:0]];
    end

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_true     <= '0;
            r_false    <= '0;
            r_open     <= 1'b0;
            r_count    <= '0;
            r_assigned <= '0;
            r_idx      <= '0;
            r_kept     <= '0;
            r_changed  <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_op)
                            OP_CLEAR: begin
                                r_true     <= '0;
                                r_false    <= '0;
                                r_count    <= '0;
                                r_assigned <= '0;
                                r_open     <= 1'b0;
                            end
                            OP_ADD_LIT: begin
                                if (!store_full) begin
                                    r_cur_pos <= new_pos;
                                    r_cur_neg <= new_neg;
                                    r_open    <= !i_clause_end;
                                    if (i_clause_end) begin
                                        r_count <= r_count + 1'b1;
                                    end
                                end
                            end
                            OP_PRESET: begin
                                if (|lit_bit) begin
                                    if (!(|(assigned_mask & lit_bit))) begin
                                        r_assigned <= r_assigned + 1'b1;
                                    end
                                    if (i_polarity) begin
                                        r_true  <= r_true | lit_bit;
                                        r_false <= r_false & ~lit_bit;
                                    end else begin
                                        r_false <= r_false | lit_bit;
                                        r_true  <= r_true & ~lit_bit;
                                    end
                                end
                            end
                            OP_PROPAGATE: begin
                                r_open    <= 1'b0;
                                r_idx     <= '0;
                                r_kept    <= '0;
                                r_changed <= 1'b0;
                                r_state   <= S_READ;
                            end
                            OP_QUERY: begin
                                o_valid          <= 1'b1;
                                o_result_kind    <= RK_QUERY;
                                o_contradiction  <= 1'b0;
                                o_assigned_count <= '0;
                                o_clauses_left   <= '0;
                                if (|(r_true & lit_bit)) begin
                                    o_var_state <= VS_TRUE;
                                end else if (|(r_false & lit_bit)) begin
                                    o_var_state <= VS_FALSE;
                                end else begin
                                    o_var_state <= VS_OPEN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    // end of pass: commit the compacted count, repeat or report
                    if (r_idx == r_count) begin
                        r_count   <= r_kept;
                        r_idx     <= '0;
                        r_kept    <= '0;
                        r_changed <= 1'b0;
                        if (!r_changed) begin
                            r_state          <= S_IDLE;
                            o_valid          <= 1'b1;
                            o_result_kind    <= RK_PROP;
                            o_contradiction  <= 1'b0;
                            o_assigned_count <= r_assigned;
                            o_clauses_left   <= LEFT_W'(r_kept);
                            o_var_state      <= VS_OPEN;
                        end
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (clause_sat) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end else if (clause_empty) begin
                        // contradiction: stop, keep the count of this pass start
                        r_state          <= S_IDLE;
                        o_valid          <= 1'b1;
                        o_result_kind    <= RK_PROP;
                        o_contradiction  <= 1'b1;
                        o_assigned_count <= r_assigned;
                        o_clauses_left   <= LEFT_W'(r_count);
                        o_var_state      <= VS_OPEN;
                    end else begin
                        if (clause_unit) begin
                            if (|(pl & open_bits)) begin
                                r_true <= r_true | open_bits;
                            end else begin
                                r_false <= r_false | open_bits;
                            end
                            r_assigned <= r_assigned + 1'b1;
                            r_changed  <= 1'b1;
                        end
                        r_kept  <= r_kept + 1'b1;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // an assignment never marks a variable both true and false
    a_masks_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_true & r_false) == '0)
        else $error("variable both true and false");

    // compaction never overtakes the read pointer
    a_kept_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_kept <= r_idx) && (r_idx <= r_count))
        else $error("compaction pointer ahead of read pointer");

    // the store never exceeds its slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_CLAUSE_SLOTS))
        else $error("clause count beyond store size");

    // a propagate command starts a sweep
    a_prop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == OP_PROPAGATE)) |=> busy)
        else $error("propagate did not start");

    // a contradiction is reported only in a propagation report
    a_contra_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_contradiction) |-> (o_result_kind == RK_PROP))
        else $error("contradiction flag on a query answer");
`endif

endmodule
